>>> rtl/core/frc_pkg.sv
package frc_pkg;

  localparam int unsigned ModuleNumberWidth = 8;
  localparam int unsigned NibbleWidth       = 4;
  localparam int unsigned AddressWidth      = 7;
  localparam int unsigned DataWidth         = 7;
  localparam int unsigned CheckWidth        = 8;

  localparam logic [CheckWidth-1:0] ReportId   = 8'h42;
  localparam logic [DataWidth-1:0]  DataBase   = 7'h40;
  localparam logic [DataWidth-1:0]  NibbleFlag = 7'h10;

  typedef struct packed {
    logic [ModuleNumberWidth-1:0] module_number;
    logic                         upper_nibble;
    logic [NibbleWidth-1:0]       nibble_data;
  } item_t;

  typedef struct packed {
    logic [AddressWidth-1:0] address_byte;
    logic [DataWidth-1:0]    data_byte;
    logic [CheckWidth-1:0]   check_byte;
    logic                    last_report;
  } report_t;

  typedef struct packed {
    logic capture;
    logic load_a;
    logic load_b;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic any_change;
    logic last;
  } sts_t;

endpackage

>>> rtl/core/frc_ctrl.sv
module frc_ctrl
  import frc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StReadA = 3'd1;
  localparam logic [2:0] StLoadA = 3'd2;
  localparam logic [2:0] StLoadB = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = StReadA;
        end
      end
      StReadA: begin
        state_d = StLoadA;
      end
      StLoadA: begin
        cmd_o.load_a = 1'b1;
        state_d      = StLoadB;
      end
      StLoadB: begin
        cmd_o.load_b = 1'b1;
        state_d      = sts_i.any_change ? StEmit : StIdle;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.last ? StIdle : StEmit;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

>>> rtl/core/frc_dp.sv
module frc_dp
  import frc_pkg::*;
#(
  parameter int unsigned MODULE_COUNT = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output sts_t    sts_o,
  output logic    result_strobe_o,
  output report_t result_o
);

  localparam int unsigned AddrW = $clog2(MODULE_COUNT);
  localparam int unsigned IdxW  = ModuleNumberWidth;

  item_t                 item_q;
  logic [7:0]            a_q;
  logic [7:0]            b_q;
  logic [3:0]            pend_q, pend_d;
  logic [7:0]            mem_q [MODULE_COUNT];
  logic [MODULE_COUNT-1:0] valid_q;
  logic [7:0]            rdata_q;
  logic                  rvalid_q;
  logic [7:0]            rd_byte;
  logic                  strobe_q;
  report_t               out_q;

  logic [IdxW-1:0]       idx_a, idx_b, idx_sel;
  logic                  rng_a, rng_b;
  logic [AddrW-1:0]      rd_addr, wr_addr;
  logic [3:0]            chg_mask;
  logic [1:0]            k;
  logic                  sel_b;
  logic [2:0]            bitpos;
  logic [7:0]            byte_cur, byte_new;
  logic                  flag;
  logic [3:0]            nib;
  logic [DataWidth-1:0]  data;

  function automatic logic [2:0] bit_of(input logic [1:0] kk, input logic up);
    logic [2:0] r;
    if (up) begin
      r = (kk == 2'd3) ? 3'd0 : 3'(kk) + 3'd5;
    end else begin
      r = 3'(kk) + 3'd1;
    end
    return r;
  endfunction

  assign idx_a = item_q.module_number - IdxW'(1);
  assign idx_b = item_q.module_number;
  assign rng_a = (item_q.module_number != '0) && ({1'b0, idx_a} < 9'(MODULE_COUNT));
  assign rng_b = (item_q.module_number != '0) && ({1'b0, idx_b} < 9'(MODULE_COUNT));

  assign rd_addr = cmd_i.load_a ? idx_b[AddrW-1:0] : idx_a[AddrW-1:0];
  assign rd_byte = rvalid_q ? rdata_q : 8'h00;

  always_comb begin
    logic       sb;
    logic [2:0] bp;
    for (int i = 0; i < 4; i++) begin
      sb = item_q.upper_nibble && (i == 3);
      bp = bit_of(2'(i), item_q.upper_nibble);
      chg_mask[i] = (sb ? rng_b : rng_a) &&
                    ((sb ? rd_byte[bp] : a_q[bp]) != item_q.nibble_data[i]);
    end
  end

  always_comb begin
    if (pend_q[0]) begin
      k = 2'd0;
    end else if (pend_q[1]) begin
      k = 2'd1;
    end else if (pend_q[2]) begin
      k = 2'd2;
    end else begin
      k = 2'd3;
    end
  end

  assign sel_b    = item_q.upper_nibble && (k == 2'd3);
  assign bitpos   = bit_of(k, item_q.upper_nibble);
  assign byte_cur = sel_b ? b_q : a_q;

  always_comb begin
    byte_new         = byte_cur;
    byte_new[bitpos] = item_q.nibble_data[k];
  end

  assign idx_sel = sel_b ? idx_b : idx_a;
  assign wr_addr = idx_sel[AddrW-1:0];
  assign flag    = bitpos[2];
  assign nib     = flag ? byte_new[7:4] : byte_new[3:0];
  assign data    = DataBase | (flag ? NibbleFlag : '0) | DataWidth'(nib);

  always_comb begin
    pend_d    = pend_q;
    if (cmd_i.load_b) begin
      pend_d = chg_mask;
    end else if (cmd_i.emit) begin
      pend_d[k] = 1'b0;
    end
  end

  assign sts_o.any_change = (chg_mask != 4'b0000);
  assign sts_o.last       = ((pend_q & ~(4'b0001 << k)) == 4'b0000);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.load_a) begin
      a_q <= rd_byte;
    end
    if (cmd_i.load_b) begin
      b_q <= rd_byte;
    end
    if (cmd_i.emit) begin
      if (sel_b) begin
        b_q <= byte_new;
      end else begin
        a_q <= byte_new;
      end
      mem_q[wr_addr] <= byte_new;
      out_q.address_byte <= idx_sel[AddressWidth-1:0];
      out_q.data_byte    <= data;
      out_q.check_byte   <= ReportId ^ idx_sel ^ {1'b0, data};
      out_q.last_report  <= sts_o.last;
    end
    rdata_q <= mem_q[rd_addr];
    pend_q  <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        valid_q[wr_addr] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr];
      strobe_q <= cmd_i.emit;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_o        = out_q;

endmodule

>>> rtl/core/feedback_change_reporter_core.sv
// Feedback change reporter. An item is taken on start while busy is low; busy then
// stays high through the cache-read states ReadA, LoadA and LoadB, then one Emit
// state per report, with up to four reports per item; the cache has a single read
// port and takes one write per report. Reports follow on consecutive cycles, each
// registered with its cache write and marked by result_strobe_o for exactly one
// cycle; the receiver cannot stall them, and last_report marks an item's last. The
// cache is cleared at reset through per-entry valid bits, with no clearing pass.
module feedback_change_reporter_core
  import frc_pkg::*;
#(
  parameter int unsigned MODULE_COUNT = 128
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    result_strobe_o,
  output report_t result_o
);

  cmd_t cmd;
  sts_t sts;

  frc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  frc_dp #(
    .MODULE_COUNT (MODULE_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (item_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule
